[rtl/core/fpq_pkg.sv]
// Shared types and codes for the Q24.8 fixed-point ALU core.
// No dependencies; every module of the core imports this package.
`default_nettype none

package fpq_pkg;

  // Width of the operand and result ports.
  localparam int PORT_WIDTH = 32;

  // Action codes carried on in_action.
  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_MIN = 3'd4;
  localparam logic [2:0] ACT_MAX = 3'd5;
  localparam logic [2:0] ACT_INC = 3'd6;
  localparam logic [2:0] ACT_DEC = 3'd7;

  // Per-word control flags that travel down the pipeline with the data.
  typedef struct packed {
    logic [2:0] action;
    logic       neg;
    logic       less;
    logic       equal;
    logic       greater;
    logic       b_zero;
  } fpq_flags_t;

  // One finished result word.
  typedef struct packed {
    logic signed [PORT_WIDTH-1:0] value;
    logic                         less;
    logic                         equal;
    logic                         greater;
    logic                         overflow;
    logic                         div_zero;
  } fpq_result_t;

endpackage

`default_nettype wire

[rtl/core/fpq_front.sv]
// Front stage: compare flags, wrapping add/sub/min/max/inc/dec, operand
// magnitudes and the rounded divide numerator. Depends on fpq_pkg.
`default_nettype none

module fpq_front
  import fpq_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         v_i,
  input  wire logic [2:0]                   action_i,
  input  wire logic signed [DATA_WIDTH-1:0] a_i,
  input  wire logic signed [DATA_WIDTH-1:0] b_i,
  output logic                              v_o,
  output fpq_flags_t                        flags_o,
  output logic [DATA_WIDTH-1:0]             mag_a_o,
  output logic [DATA_WIDTH-1:0]             mag_b_o,
  output logic [DATA_WIDTH-1:0]             simple_o,
  output logic [DATA_WIDTH+FRAC_BITS:0]     num_o
);

  localparam int NUM_WIDTH = DATA_WIDTH + FRAC_BITS + 1;

  logic                  v_r;
  fpq_flags_t            flags_r, flags_nxt;
  logic [DATA_WIDTH-1:0] mag_a_r, mag_a_nxt;
  logic [DATA_WIDTH-1:0] mag_b_r, mag_b_nxt;
  logic [DATA_WIDTH-1:0] simple_r, simple_nxt;
  logic [NUM_WIDTH-1:0]  num_r, num_nxt;

  // Flags and magnitudes.
  always_comb begin
    flags_nxt.action  = action_i;
    flags_nxt.neg     = a_i[DATA_WIDTH-1] ^ b_i[DATA_WIDTH-1];
    flags_nxt.less    = a_i < b_i;
    flags_nxt.equal   = a_i == b_i;
    flags_nxt.greater = a_i > b_i;
    flags_nxt.b_zero  = b_i == '0;
    mag_a_nxt = a_i[DATA_WIDTH-1] ? DATA_WIDTH'(-a_i) : DATA_WIDTH'(a_i);
    mag_b_nxt = b_i[DATA_WIDTH-1] ? DATA_WIDTH'(-b_i) : DATA_WIDTH'(b_i);
  end

  // Divide numerator 2*|a|*2^FRAC_BITS + |b|, so that a floor divide by 2*|b|
  // rounds half away from zero.
  assign num_nxt = {mag_a_nxt, {(FRAC_BITS + 1){1'b0}}} + NUM_WIDTH'(mag_b_nxt);

  // Results of the actions that need no multiply or divide.
  always_comb begin
    unique case (action_i)
      ACT_ADD: simple_nxt = DATA_WIDTH'(a_i + b_i);
      ACT_SUB: simple_nxt = DATA_WIDTH'(a_i - b_i);
      ACT_MUL: simple_nxt = '0;
      ACT_DIV: simple_nxt = '0;
      ACT_MIN: simple_nxt = flags_nxt.less ? a_i : b_i;
      ACT_MAX: simple_nxt = flags_nxt.greater ? a_i : b_i;
      ACT_INC: simple_nxt = DATA_WIDTH'(a_i + DATA_WIDTH'(1));
      ACT_DEC: simple_nxt = DATA_WIDTH'(a_i - DATA_WIDTH'(1));
    endcase
  end

  // Stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (en) begin
      flags_r  <= flags_nxt;
      mag_a_r  <= mag_a_nxt;
      mag_b_r  <= mag_b_nxt;
      simple_r <= simple_nxt;
      num_r    <= num_nxt;
    end
  end

  assign v_o      = v_r;
  assign flags_o  = flags_r;
  assign mag_a_o  = mag_a_r;
  assign mag_b_o  = mag_b_r;
  assign simple_o = simple_r;
  assign num_o    = num_r;

endmodule

`default_nettype wire

[rtl/core/fpq_div_cell.sv]
// One cell of the divider chain: a single restoring step that produces one
// quotient bit and passes the word on. Depends on fpq_pkg.
`default_nettype none

module fpq_div_cell
  import fpq_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          v_i,
  input  wire fpq_flags_t                    flags_i,
  input  wire logic [DATA_WIDTH-1:0]         mag_a_i,
  input  wire logic [DATA_WIDTH-1:0]         mag_b_i,
  input  wire logic [DATA_WIDTH-1:0]         simple_i,
  input  wire logic [DATA_WIDTH-1:0]         rem_i,
  input  wire logic [DATA_WIDTH+FRAC_BITS:0] nq_i,
  output logic                               v_o,
  output fpq_flags_t                         flags_o,
  output logic [DATA_WIDTH-1:0]              mag_a_o,
  output logic [DATA_WIDTH-1:0]              mag_b_o,
  output logic [DATA_WIDTH-1:0]              simple_o,
  output logic [DATA_WIDTH-1:0]              rem_o,
  output logic [DATA_WIDTH+FRAC_BITS:0]      nq_o
);

  localparam int NUM_WIDTH = DATA_WIDTH + FRAC_BITS + 1;

  logic                  v_r;
  fpq_flags_t            flags_r;
  logic [DATA_WIDTH-1:0] mag_a_r;
  logic [DATA_WIDTH-1:0] mag_b_r;
  logic [DATA_WIDTH-1:0] simple_r;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [NUM_WIDTH-1:0]  nq_r, nq_nxt;
  logic [DATA_WIDTH:0]   den;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  q_bit;

  // Shift the next numerator bit into the remainder and try the divisor 2*|b|.
  // The numerator shifts out at the top while quotient bits fill the bottom.
  always_comb begin
    den     = {mag_b_i, 1'b0};
    trial   = {rem_i, nq_i[NUM_WIDTH-1]};
    diff    = trial - den;
    q_bit   = trial >= den;
    rem_nxt = q_bit ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
    nq_nxt  = {nq_i[NUM_WIDTH-2:0], q_bit};
  end

  // Cell valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  // Cell payload.
  always_ff @(posedge clk) begin
    if (en) begin
      flags_r  <= flags_i;
      mag_a_r  <= mag_a_i;
      mag_b_r  <= mag_b_i;
      simple_r <= simple_i;
      rem_r    <= rem_nxt;
      nq_r     <= nq_nxt;
    end
  end

  assign v_o      = v_r;
  assign flags_o  = flags_r;
  assign mag_a_o  = mag_a_r;
  assign mag_b_o  = mag_b_r;
  assign simple_o = simple_r;
  assign rem_o    = rem_r;
  assign nq_o     = nq_r;

endmodule

`default_nettype wire

[rtl/core/fpq_back.sv]
// Back end: magnitude multiply, rounding, saturation, result selection and
// the output register with its skid word. Depends on fpq_pkg.
`default_nettype none

module fpq_back
  import fpq_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          v_i,
  input  wire fpq_flags_t                    flags_i,
  input  wire logic [DATA_WIDTH-1:0]         mag_a_i,
  input  wire logic [DATA_WIDTH-1:0]         mag_b_i,
  input  wire logic [DATA_WIDTH-1:0]         simple_i,
  input  wire logic [DATA_WIDTH+FRAC_BITS:0] quo_i,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output fpq_result_t                        out_word,
  output logic                               full
);

  localparam int NUM_WIDTH  = DATA_WIDTH + FRAC_BITS + 1;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int SAT_WIDTH  = (PROD_WIDTH > NUM_WIDTH) ? PROD_WIDTH : NUM_WIDTH;
  localparam logic [PROD_WIDTH-1:0] RND =
    ({{(PROD_WIDTH - 1){1'b0}}, 1'b1} << FRAC_BITS) >> 1;
  localparam logic [SAT_WIDTH-1:0] POS_LIM =
    {{(SAT_WIDTH - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic [SAT_WIDTH-1:0] NEG_LIM = POS_LIM + SAT_WIDTH'(1);

  logic                         pv_r;
  fpq_flags_t                   pflags_r;
  logic [PROD_WIDTH-1:0]        prod_r;
  logic [NUM_WIDTH-1:0]         quo_r;
  logic [DATA_WIDTH-1:0]        simple_r;

  logic [PROD_WIDTH-1:0]        rounded;
  logic [PROD_WIDTH-1:0]        mul_mag;
  logic [SAT_WIDTH-1:0]         mag_sel;
  logic [SAT_WIDTH-1:0]         lim;
  logic                         sat;
  logic [DATA_WIDTH-1:0]        mag_clip;
  logic signed [DATA_WIDTH-1:0] signed_res;
  logic signed [DATA_WIDTH-1:0] final_res;
  fpq_result_t                  res;

  logic                         out_valid_r;
  fpq_result_t                  out_r;
  logic                         skid_full_r;
  fpq_result_t                  skid_r;
  logic                         take;

  // Product stage: unsigned magnitude multiply, registered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pflags_r <= flags_i;
      prod_r   <= PROD_WIDTH'(mag_a_i) * PROD_WIDTH'(mag_b_i);
      quo_r    <= quo_i;
      simple_r <= simple_i;
    end
  end

  // Round the product half away from zero, then clamp the chosen magnitude.
  always_comb begin
    rounded  = prod_r + RND;
    mul_mag  = rounded >> FRAC_BITS;
    mag_sel  = (pflags_r.action == ACT_MUL) ? SAT_WIDTH'(mul_mag) : SAT_WIDTH'(quo_r);
    lim      = pflags_r.neg ? NEG_LIM : POS_LIM;
    sat      = mag_sel > lim;
    mag_clip = sat ? lim[DATA_WIDTH-1:0] : mag_sel[DATA_WIDTH-1:0];
    signed_res = pflags_r.neg ? DATA_WIDTH'(-mag_clip) : mag_clip;
  end

  // Pick the result and flags for the action.
  always_comb begin
    final_res    = simple_r;
    res.overflow = 1'b0;
    res.div_zero = 1'b0;
    if (pflags_r.action == ACT_MUL) begin
      final_res    = signed_res;
      res.overflow = sat;
    end else if (pflags_r.action == ACT_DIV) begin
      final_res    = pflags_r.b_zero ? '0 : signed_res;
      res.overflow = !pflags_r.b_zero && sat;
      res.div_zero = pflags_r.b_zero;
    end
    res.value   = PORT_WIDTH'(final_res);
    res.less    = pflags_r.less;
    res.equal   = pflags_r.equal;
    res.greater = pflags_r.greater;
  end

  // Output register with one skid word behind it. The pipeline halts only
  // while the skid word is occupied.
  assign take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (take) begin
        skid_full_r <= 1'b0;
      end
    end else if (!out_valid_r || take) begin
      out_valid_r <= pv_r;
    end else if (pv_r) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (!out_valid_r || take) begin
      out_r <= res;
    end else if (pv_r) begin
      skid_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign full      = skid_full_r;

endmodule

`default_nettype wire

[rtl/core/fixed_point_q24_8_alu_core.sv]
// Q24.8 fixed-point ALU core: add, subtract, multiply, divide, min, max,
// increment and decrement on signed raw operands. Depends on fpq_pkg,
// fpq_front, fpq_div_cell and fpq_back.
//
// Use: present a word on in_action / in_operand_a / in_operand_b with
// in_valid; it is taken at a rising edge where in_valid is high and in_stall
// is low. Each word yields one result word on the out_ ports, taken at an
// edge where out_valid is high and out_stall is low. Results leave in order.
// Every word passes the input register, the front stage, the divider chain
// of DATA_WIDTH + FRAC_BITS + 1 cells that each settle one quotient bit, the
// multiplier stage and the output register, in that order.
// Throughput is one word per cycle while in_stall is low: every action goes
// down the same chain.
// When the receiver stalls, the output register holds its word and one
// more word lands in a skid register; only then does in_stall rise and the
// whole chain halt in place. After a synchronous reset (rst_n low) the
// pipeline is empty, out_valid and in_stall are low.
`default_nettype none

module fixed_point_q24_8_alu_core
  import fpq_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [2:0]                   in_action,
  input  wire logic signed [PORT_WIDTH-1:0] in_operand_a,
  input  wire logic signed [PORT_WIDTH-1:0] in_operand_b,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [PORT_WIDTH-1:0]      out_result_value,
  output logic                              out_a_less,
  output logic                              out_a_equal,
  output logic                              out_a_greater,
  output logic                              out_overflow,
  output logic                              out_divide_by_zero
);

  localparam int NUM_WIDTH = DATA_WIDTH + FRAC_BITS + 1;

  logic                         en;
  logic                         full;
  logic                         v0_r;
  logic [2:0]                   action_r;
  logic signed [DATA_WIDTH-1:0] a_r;
  logic signed [DATA_WIDTH-1:0] b_r;
  fpq_result_t                  out_word;

  // Divider chain taps, one per cell boundary.
  logic                  c_v      [0:NUM_WIDTH];
  fpq_flags_t            c_flags  [0:NUM_WIDTH];
  logic [DATA_WIDTH-1:0] c_mag_a  [0:NUM_WIDTH];
  logic [DATA_WIDTH-1:0] c_mag_b  [0:NUM_WIDTH];
  logic [DATA_WIDTH-1:0] c_simple [0:NUM_WIDTH];
  logic [DATA_WIDTH-1:0] c_rem    [0:NUM_WIDTH];
  logic [NUM_WIDTH-1:0]  c_nq     [0:NUM_WIDTH];

  // The whole pipeline advances unless the skid word is occupied.
  assign en       = !full;
  assign in_stall = full;

  // Input register; operands keep their low DATA_WIDTH bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      action_r <= in_action;
      a_r      <= in_operand_a[DATA_WIDTH-1:0];
      b_r      <= in_operand_b[DATA_WIDTH-1:0];
    end
  end

  fpq_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_i      (v0_r),
    .action_i (action_r),
    .a_i      (a_r),
    .b_i      (b_r),
    .v_o      (c_v[0]),
    .flags_o  (c_flags[0]),
    .mag_a_o  (c_mag_a[0]),
    .mag_b_o  (c_mag_b[0]),
    .simple_o (c_simple[0]),
    .num_o    (c_nq[0])
  );

  // The partial remainder starts at zero.
  assign c_rem[0] = '0;

  // Divider chain: one restoring step per cell.
  for (genvar i = 0; i < NUM_WIDTH; i++) begin : g_cell
    fpq_div_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .v_i      (c_v[i]),
      .flags_i  (c_flags[i]),
      .mag_a_i  (c_mag_a[i]),
      .mag_b_i  (c_mag_b[i]),
      .simple_i (c_simple[i]),
      .rem_i    (c_rem[i]),
      .nq_i     (c_nq[i]),
      .v_o      (c_v[i+1]),
      .flags_o  (c_flags[i+1]),
      .mag_a_o  (c_mag_a[i+1]),
      .mag_b_o  (c_mag_b[i+1]),
      .simple_o (c_simple[i+1]),
      .rem_o    (c_rem[i+1]),
      .nq_o     (c_nq[i+1])
    );
  end

  fpq_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .v_i       (c_v[NUM_WIDTH]),
    .flags_i   (c_flags[NUM_WIDTH]),
    .mag_a_i   (c_mag_a[NUM_WIDTH]),
    .mag_b_i   (c_mag_b[NUM_WIDTH]),
    .simple_i  (c_simple[NUM_WIDTH]),
    .quo_i     (c_nq[NUM_WIDTH]),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .full      (full)
  );

  assign out_result_value   = out_word.value;
  assign out_a_less         = out_word.less;
  assign out_a_equal        = out_word.equal;
  assign out_a_greater      = out_word.greater;
  assign out_overflow       = out_word.overflow;
  assign out_divide_by_zero = out_word.div_zero;

  // The skid word is only occupied behind a held output word.
  a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no output word pending");

  // A held output with a full skid keeps the input stalled.
  a_stall_persists: assert property (@(posedge clk) disable iff (!rst_n)
    (in_stall && out_stall) |=> in_stall)
    else $error("skid word dropped while output was stalled");

  // Exactly one compare flag per result word.
  a_compare_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_a_less, out_a_equal, out_a_greater}))
    else $error("compare flags not one-hot");

  // Divide by zero gives a zero result and no overflow.
  a_div_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |-> (out_result_value == '0 && !out_overflow))
    else $error("divide by zero result not cleared");

endmodule

`default_nettype wire

[test/fixed_point_q24_8_alu_core_tb.sv]
// Self-checking testbench for the Q24.8 fixed-point ALU core: a directed table
// followed by random words, each result checked against a hand-typed word or a behavioral predictor.
// Depends on fpq_pkg and fixed_point_q24_8_alu_core.
`timescale 1ns / 100ps

module fixed_point_q24_8_alu_core_tb;
  import fpq_pkg::*;

  localparam int DATA_WIDTH   = 32;
  localparam int FRAC_BITS    = 8;
  localparam int RANDOM_WORDS = 1200;
  localparam int DRAIN_CYCLES = 60;
  localparam int STUCK_LIMIT  = 2000;

  // One row of the directed table. When checked_by_hand is set, the typed
  // result is expected; otherwise the predictor supplies it. The result flags
  // are packed as {less, equal, greater, overflow, div_zero}.
  typedef struct packed {
    logic [2:0]             act;
    logic [PORT_WIDTH-1:0]  a;
    logic [PORT_WIDTH-1:0]  b;
    logic                   checked_by_hand;
    fpq_result_t            want;
  } alu_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam alu_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Wrapping add and subtract.
    '{ACT_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, {32'h8000_0000, 5'b00100}},
    '{ACT_SUB, 32'h8000_0000, 32'h0000_0001, 1'b1, {32'h7FFF_FFFF, 5'b10000}},
    '{ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{ACT_SUB, 32'h0000_0000, 32'h8000_0000, 1'b0, '0},
    // Multiply saturation at both bounds.
    '{ACT_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, {32'h7FFF_FFFF, 5'b01010}},
    '{ACT_MUL, 32'h8000_0000, 32'h8000_0000, 1'b1, {32'h7FFF_FFFF, 5'b01010}},
    '{ACT_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, {32'h8000_0000, 5'b10010}},
    // Multiply by one, and rounding half away from zero.
    '{ACT_MUL, 32'h0000_0100, 32'h0000_0100, 1'b1, {32'h0000_0100, 5'b01000}},
    '{ACT_MUL, 32'h0000_0001, 32'h0000_0080, 1'b1, {32'h0000_0001, 5'b10000}},
    '{ACT_MUL, 32'hFFFF_FFFF, 32'h0000_0080, 1'b1, {32'hFFFF_FFFF, 5'b10000}},
    '{ACT_MUL, 32'h0000_0001, 32'h0000_007F, 1'b0, '0},
    // A negative product that rounds to zero gives plain zero.
    '{ACT_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, {32'h0000_0000, 5'b10000}},
    // Divide by zero.
    '{ACT_DIV, 32'h1234_5600, 32'h0000_0000, 1'b1, {32'h0000_0000, 5'b00101}},
    '{ACT_DIV, 32'h0000_0000, 32'h0000_0000, 1'b1, {32'h0000_0000, 5'b01001}},
    // Divide saturation, divide by one and quotient rounding.
    '{ACT_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, {32'h7FFF_FFFF, 5'b10010}},
    '{ACT_DIV, 32'h0000_0100, 32'h0000_0100, 1'b1, {32'h0000_0100, 5'b01000}},
    '{ACT_DIV, 32'h0000_0001, 32'h0000_0200, 1'b1, {32'h0000_0001, 5'b10000}},
    '{ACT_DIV, 32'hFFFF_FFFF, 32'h0000_0200, 1'b0, '0},
    '{ACT_DIV, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, '0},
    '{ACT_DIV, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
    // Min and max, equal operands included.
    '{ACT_MIN, 32'h0000_0005, 32'h0000_0005, 1'b1, {32'h0000_0005, 5'b01000}},
    '{ACT_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, {32'h8000_0000, 5'b10000}},
    '{ACT_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, {32'h7FFF_FFFF, 5'b10000}},
    // Increment and decrement wrap.
    '{ACT_INC, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, {32'h8000_0000, 5'b00100}},
    '{ACT_DEC, 32'h8000_0000, 32'h0000_0000, 1'b1, {32'h7FFF_FFFF, 5'b10000}}
  };

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [2:0]                    in_action = ACT_ADD;
  logic signed [PORT_WIDTH-1:0]  in_operand_a = '0;
  logic signed [PORT_WIDTH-1:0]  in_operand_b = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [PORT_WIDTH-1:0]  out_result_value;
  logic                          out_a_less;
  logic                          out_a_equal;
  logic                          out_a_greater;
  logic                          out_overflow;
  logic                          out_divide_by_zero;

  fpq_result_t expected_words [$];
  int          mismatch_count = 0;
  int          stall_left = 0;
  int          stuck_cycles = 0;
  bit          quiet = 1'b0;

  fixed_point_q24_8_alu_core #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_operand_a      (in_operand_a),
    .in_operand_b      (in_operand_b),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_value  (out_result_value),
    .out_a_less        (out_a_less),
    .out_a_equal       (out_a_equal),
    .out_a_greater     (out_a_greater),
    .out_overflow      (out_overflow),
    .out_divide_by_zero(out_divide_by_zero)
  );

  // Free-running 100 MHz clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Clamp a signed magnitude to the 32-bit range and flag any clipping.
  function automatic fpq_result_t clamp_to_word(input fpq_result_t r,
                                                input longint unsigned mag,
                                                input bit neg);
    fpq_result_t o;
    o = r;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        o.overflow = 1'b1;
        mag = 64'h8000_0000;
      end
      o.value = PORT_WIDTH'(-mag);
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        o.overflow = 1'b1;
        mag = 64'h7FFF_FFFF;
      end
      o.value = PORT_WIDTH'(mag);
    end
    return o;
  endfunction

  // Work out the result word that one input word must produce.
  function automatic fpq_result_t predict_alu_word(input logic [2:0] act,
                                                   input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    fpq_result_t     r;
    longint          sa;
    longint          sb;
    longint unsigned mag_a;
    longint unsigned mag_b;
    longint unsigned mag;
    bit              neg;
    r = '0;
    sa = a;
    sb = b;
    mag_a = (sa < 0) ? longint'(-sa) : sa;
    mag_b = (sb < 0) ? longint'(-sb) : sb;
    neg = (sa < 0) != (sb < 0);
    r.less    = a < b;
    r.equal   = a == b;
    r.greater = a > b;
    case (act)
      ACT_ADD: r.value = a + b;
      ACT_SUB: r.value = a - b;
      ACT_MUL: begin
        mag = (mag_a * mag_b + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        r = clamp_to_word(r, mag, neg && mag != 0);
      end
      ACT_DIV: begin
        if (sb == 0) begin
          r.div_zero = 1'b1;
          r.value = '0;
        end else begin
          mag = ((mag_a << (FRAC_BITS + 1)) + mag_b) / (2 * mag_b);
          r = clamp_to_word(r, mag, neg && mag != 0);
        end
      end
      ACT_MIN: r.value = (a < b) ? a : b;
      ACT_MAX: r.value = (a > b) ? a : b;
      ACT_INC: r.value = a + 32'sd1;
      default: r.value = a - 32'sd1;
    endcase
    return r;
  endfunction

  // Operands that favor extremes, small values and powers of two.
  function automatic logic signed [31:0] pick_operand();
    logic signed [31:0] v;
    case ($urandom_range(0, 7))
      3: v = int'($urandom_range(0, 4095)) - 2048;
      4: begin
        case ($urandom_range(0, 6))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = 32'sd0;
          3: v = 32'sd1;
          4: v = -32'sd1;
          5: v = 32'sd256;
          default: v = -32'sd256;
        endcase
      end
      5: v = int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      6: begin
        v = 32'sd1 <<< $urandom_range(0, 30);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Print one mismatch line and count it.
  task automatic flag_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Present one word and hold it until it is taken; then its result is due.
  task automatic drive_word(input logic [2:0] act, input logic signed [31:0] a,
                            input logic signed [31:0] b, input fpq_result_t want);
    in_valid     <= 1'b1;
    in_action    <= act;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (in_stall);
    expected_words.push_back(want);
  endtask

  // A random burst of idle cycles on the input side.
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Receiver: check every result word taken, and stall in random bursts.
  always @(posedge clk) begin
    fpq_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        flag_mismatch($sformatf("result word %h with nothing expected",
                                out_result_value));
      end else begin
        want = expected_words.pop_front();
        if (out_result_value !== want.value)
          flag_mismatch($sformatf("value %h, expected %h", out_result_value,
                                  want.value));
        if (out_a_less !== want.less)
          flag_mismatch($sformatf("a_less %b, expected %b", out_a_less, want.less));
        if (out_a_equal !== want.equal)
          flag_mismatch($sformatf("a_equal %b, expected %b", out_a_equal,
                                  want.equal));
        if (out_a_greater !== want.greater)
          flag_mismatch($sformatf("a_greater %b, expected %b", out_a_greater,
                                  want.greater));
        if (out_overflow !== want.overflow)
          flag_mismatch($sformatf("overflow %b, expected %b", out_overflow,
                                  want.overflow));
        if (out_divide_by_zero !== want.div_zero)
          flag_mismatch($sformatf("divide_by_zero %b, expected %b",
                                  out_divide_by_zero, want.div_zero));
      end
    end
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles = stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("fixed_point_q24_8_alu_core_tb: errors");
      $finish;
    end
  end

  // Stimulus: reset, the directed table, then random words.
  initial begin
    logic [2:0]         act;
    logic signed [31:0] a;
    logic signed [31:0] b;
    fpq_result_t        want;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      want = DIRECTED[i].checked_by_hand ? DIRECTED[i].want :
             predict_alu_word(DIRECTED[i].act, DIRECTED[i].a, DIRECTED[i].b);
      drive_word(DIRECTED[i].act, DIRECTED[i].a, DIRECTED[i].b, want);
      sender_gap();
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // Two stretches run with no idling on either side.
      quiet = (i >= 400 && i < 520) || (i >= RANDOM_WORDS - 200);
      act = 3'($urandom_range(0, 7));
      a = pick_operand();
      b = ($urandom_range(0, 15) == 0) ? a : pick_operand();
      if (act == ACT_DIV && $urandom_range(0, 9) == 0) b = '0;
      drive_word(act, a, b, predict_alu_word(act, a, b));
      if (i == 700) begin
        // Let the pipeline empty completely before going on.
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
      end else begin
        sender_gap();
      end
    end

    // Wait for the last results, then a little longer for strays.
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("fixed_point_q24_8_alu_core_tb: clean");
    end else begin
      $display("fixed_point_q24_8_alu_core_tb: errors");
    end
    $finish;
  end

endmodule
